// ===== design/ucn_pkg.sv =====
`default_nettype none

package ucn_pkg;

    // component kinds
    localparam logic [2:0] KIND_SCHEME    = 3'd0;
    localparam logic [2:0] KIND_USERINFO  = 3'd1;
    localparam logic [2:0] KIND_HOST      = 3'd2;
    localparam logic [2:0] KIND_PATH      = 3'd3;
    localparam logic [2:0] KIND_QUERY     = 3'd4;
    localparam logic [2:0] KIND_FRAGMENT  = 3'd5;
    localparam logic [2:0] KIND_IPVFUTURE = 3'd6;
    localparam logic [2:0] KIND_RESET     = KIND_PATH;

    // register map
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [0:0] REG_COMPONENT_KIND = 1'b0;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic       escape;   // three words: '%', hi, lo
        logic [7:0] data;     // single word payload
        logic [7:0] hi_char;
        logic [7:0] lo_char;
        logic       done;
        logic       err;
    } t_cmd;

    function automatic logic is_alpha(input logic [7:0] b);
        logic [7:0] l;
        l = b | 8'h20;
        return (l >= 8'h61) && (l <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic hex_ok(input logic [7:0] b);
        return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
               ((b >= 8'h41) && (b <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (is_digit(b)) begin
            v = b - 8'h30;
        end else if ((b >= 8'h61) && (b <= 8'h66)) begin
            v = b - 8'h57;
        end else begin
            v = b - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'h20) : b;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;
    endfunction

    function automatic logic allowed(input logic [2:0] kind, input logic [7:0] b);
        logic unres;
        logic sub;
        logic pchar;
        logic res;
        unres = is_alpha(b) || is_digit(b) || (b == 8'h2D) || (b == 8'h2E) ||
                (b == 8'h5F) || (b == 8'h7E);
        sub   = (b == 8'h21) || (b == 8'h24) || ((b >= 8'h26) && (b <= 8'h2C)) ||
                (b == 8'h3B) || (b == 8'h3D);
        pchar = unres || sub || (b == 8'h3A) || (b == 8'h40);
        unique case (kind)
            KIND_SCHEME: begin
                res = is_alpha(b) || is_digit(b) || (b == 8'h2B) || (b == 8'h2D) ||
                      (b == 8'h2E);
            end
            KIND_USERINFO, KIND_IPVFUTURE: begin
                res = unres || sub || (b == 8'h3A);
            end
            KIND_HOST: begin
                res = unres || sub;
            end
            KIND_QUERY, KIND_FRAGMENT: begin
                res = pchar || (b == 8'h2F) || (b == 8'h3F);
            end
            default: begin
                res = pchar || (b == 8'h2F);
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/ucn_stream_if.sv =====
`default_nettype none

interface ucn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface ucn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
    logic       error;

    modport source (output valid, output out_byte, output run_last,
                    output string_done, output error, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input string_done, input error, output ready);
endinterface

`default_nettype wire

// ===== design/uri_component_normalizer_core.sv =====
`default_nettype none

// channel   dir  handshake      payload
// i_item    in   valid/ready    in_byte[7:0], end_of_string
// o_result  out  valid/ready    out_byte[7:0], run_last, string_done, error
// apb       in   psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// one input byte per cycle; the front classifies it in the accept cycle and
// queues at most one command, so the front never waits on anything but a full queue
// the back sends one word per cycle while o_result is ready, three for a re-escape, which the queue absorbs
// an accepted byte's command passes through the queue, then the back's output register, on to o_result
// reset (synchronous, active low) empties queue and output, component_kind back to path
// o_result stalls fill the queue, then i_item.ready drops

module uri_component_normalizer_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    ucn_in_if.sink                           i_item,
    ucn_out_if.source                        o_result,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [ucn_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire [ucn_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [ucn_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    // config register, picks the allowed set
    logic [2:0] r_kind;

    logic          cfg_wr;
    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    ucn_pkg::t_cmd push_cmd;
    ucn_pkg::t_cmd head_cmd;

    // apb: no wait states, register index sits at paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == ucn_pkg::REG_COMPONENT_KIND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= ucn_pkg::KIND_RESET;
        end else if (cfg_wr) begin
            r_kind <= pwdata[2:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ucn_pkg::REG_COMPONENT_KIND) begin
            prdata[2:0] = r_kind;
        end
    end

    // front: escape tracking and classification
    ucn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_kind    (r_kind),
        .i_valid   (i_item.valid),
        .i_in_byte (i_item.in_byte),
        .i_end     (i_item.end_of_string),
        .o_ready   (i_item.ready),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_cmd     (push_cmd)
    );

    // decoupling queue of commands
    ucn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // back: expands commands into output words behind an output register
    ucn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (q_pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// ===== design/ucn_front.sv =====
`default_nettype none

module ucn_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [2:0]        i_kind,
    input  wire              i_valid,
    input  wire [7:0]        i_in_byte,
    input  wire              i_end,
    output logic             o_ready,
    input  wire              i_q_full,
    output logic             o_push,
    output ucn_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_HEX1 = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_first_hex, n_first_hex;
    logic       r_at_start, n_at_start;
    logic       r_failed, n_failed;

    logic          accept;
    logic          emit;
    logic          fail;
    logic [7:0]    dec;
    ucn_pkg::t_cmd cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign dec     = {ucn_pkg::hex_val(r_first_hex), ucn_pkg::hex_val(i_in_byte)};

    always_comb begin
        n_phase     = r_phase;
        n_first_hex = r_first_hex;
        n_at_start  = r_at_start;
        n_failed    = r_failed;
        emit        = 1'b0;
        fail        = 1'b0;
        cmd         = '0;
        if (i_end) begin
            emit        = 1'b1;
            cmd.done    = 1'b1;
            cmd.err     = r_failed || (r_phase != PH_IDLE) ||
                          ((i_kind == ucn_pkg::KIND_SCHEME) && r_at_start);
            n_phase     = PH_IDLE;
            n_first_hex = '0;
            n_at_start  = 1'b1;
            n_failed    = 1'b0;
        end else if (!r_failed) begin
            n_at_start = 1'b0;
            if (i_kind == ucn_pkg::KIND_SCHEME) begin
                n_phase = PH_IDLE;
                if (ucn_pkg::allowed(i_kind, i_in_byte) &&
                    (!r_at_start || ucn_pkg::is_alpha(i_in_byte))) begin
                    emit     = 1'b1;
                    cmd.data = ucn_pkg::to_lower(i_in_byte);
                end else begin
                    fail = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (i_in_byte == ucn_pkg::CHAR_PERCENT) begin
                            n_phase = PH_PCT;
                        end else if (ucn_pkg::allowed(i_kind, i_in_byte)) begin
                            emit     = 1'b1;
                            cmd.data = i_in_byte;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_PCT: begin
                        if (ucn_pkg::hex_ok(i_in_byte)) begin
                            n_first_hex = i_in_byte;
                            n_phase     = PH_HEX1;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    default: begin
                        // first digit was checked on its way in
                        if (ucn_pkg::hex_ok(i_in_byte) && ucn_pkg::hex_ok(r_first_hex)) begin
                            n_phase = PH_IDLE;
                            emit    = 1'b1;
                            if (ucn_pkg::allowed(i_kind, dec)) begin
                                cmd.data = dec;
                            end else begin
                                cmd.escape  = 1'b1;
                                cmd.hi_char = ucn_pkg::to_upper(r_first_hex);
                                cmd.lo_char = ucn_pkg::to_upper(i_in_byte);
                            end
                        end else begin
                            fail = 1'b1;
                        end
                    end
                endcase
            end
            if (fail) begin
                n_failed = 1'b1;
                n_phase  = PH_IDLE;
                emit     = 1'b1;
                cmd      = '0;
                cmd.err  = 1'b1;
            end
        end
    end

    assign o_push = accept && emit;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_first_hex <= '0;
            r_at_start  <= 1'b1;
            r_failed    <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_first_hex <= n_first_hex;
            r_at_start  <= n_at_start;
            r_failed    <= n_failed;
        end
    end

`ifndef SYNTHESIS
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("escape phase left its range");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end |=> r_at_start && !r_failed && (r_phase == PH_IDLE))
        else $error("end of string did not clear stream state");
`endif

endmodule

`default_nettype wire

// ===== design/ucn_queue.sv =====
`default_nettype none

module ucn_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  ucn_pkg::t_cmd    i_cmd,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output ucn_pkg::t_cmd    o_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ucn_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== design/ucn_back.sv =====
`default_nettype none

module ucn_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_valid,
    input  ucn_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    ucn_out_if.source        o_result
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_out_byte;
    logic       r_run_last;
    logic       r_done;
    logic       r_err;

    logic       load;
    logic       last;
    logic [7:0] word;

    assign load  = i_q_valid && (!r_valid || o_result.ready);
    assign last  = !i_cmd.escape || (r_idx == 2'd2);
    assign o_pop = load && last;

    always_comb begin
        if (!i_cmd.escape) begin
            word = i_cmd.data;
        end else if (r_idx == 2'd0) begin
            word = ucn_pkg::CHAR_PERCENT;
        end else if (r_idx == 2'd1) begin
            word = i_cmd.hi_char;
        end else begin
            word = i_cmd.lo_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= word;
            r_run_last <= last;
            r_done     <= i_cmd.done;
            r_err      <= i_cmd.err;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.out_byte    = r_out_byte;
    assign o_result.run_last    = r_run_last;
    assign o_result.string_done = r_done;
    assign o_result.error       = r_err;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("expansion index out of range");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_done || r_err) |-> r_run_last && (r_out_byte == 8'd0))
        else $error("terminator or error word not a lone zero word");
`endif

endmodule

`default_nettype wire

// ===== tb/uri_component_normalizer_core_tb.sv =====
module uri_component_normalizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // register addresses, one 32-bit register every four bytes
    localparam logic [ucn_pkg::CFG_ADDR_W-1:0] ADDR_KIND  =
        ucn_pkg::CFG_ADDR_W'(4 * ucn_pkg::REG_COMPONENT_KIND);
    localparam logic [ucn_pkg::CFG_ADDR_W-1:0] ADDR_SPARE = ucn_pkg::CFG_ADDR_W'(4);
    localparam logic [2:0]            KIND_SPARE = 3'd7;   // unused code, acts as path
    localparam int QUIET_CYCLES = 8;                       // drain time for the pipe plus margin
    localparam int IDLE_PCT     = 21;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_AFTER_PCT,
        ESC_AFTER_HI
    } t_esc_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
        logic       error;
    } t_norm_word;

    logic i_clk;
    logic i_rst_n;

    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ucn_pkg::CFG_ADDR_W-1:0] paddr;
    logic [ucn_pkg::CFG_DATA_W-1:0] pwdata;
    logic [ucn_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    ucn_in_if  byte_ch ();
    ucn_out_if word_ch ();

    uri_component_normalizer_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (byte_ch),
        .o_result (word_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // normaliser state as the testbench sees it
    logic [2:0]  kind_model;
    t_esc_phase  esc_model;
    logic [7:0]  hex_hi_model;
    bit          at_start_model;
    bit          aborted_model;

    t_norm_word  pending_words[$];   // words still owed by the block, oldest first
    int          mismatches;
    int          live_items;         // accepted items, dropped ones included
    bit          steady;             // no idling on either side while set

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous ceiling, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // character classes, written out per rfc 3986
    // ------------------------------------------------------------------
    function automatic bit is_letter(input logic [7:0] b);
        logic [7:0] l;
        l = b | 8'h20;
        return (l >= "a") && (l <= "z");
    endfunction

    function automatic bit is_dec(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic int hex_digit(input logic [7:0] b);
        if (is_dec(b)) return int'(b - "0");
        if ((b >= "a") && (b <= "f")) return int'(b - "a") + 10;
        if ((b >= "A") && (b <= "F")) return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] up_case(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) ? b - 8'd32 : b;
    endfunction

    function automatic logic [7:0] low_case(input logic [7:0] b);
        return ((b >= "A") && (b <= "Z")) ? b + 8'd32 : b;
    endfunction

    function automatic bit char_ok(input logic [2:0] kind, input logic [7:0] b);
        bit unres;
        bit sub;
        bit pchar;
        unres = is_letter(b) || is_dec(b) || (b == "-") || (b == ".") ||
                (b == "_") || (b == "~");
        sub   = (b == "!") || (b == "$") || ((b >= "&") && (b <= ",")) ||
                (b == ";") || (b == "=");
        pchar = unres || sub || (b == ":") || (b == "@");
        case (kind)
            ucn_pkg::KIND_SCHEME: begin
                return is_letter(b) || is_dec(b) || (b == "+") || (b == "-") || (b == ".");
            end
            ucn_pkg::KIND_USERINFO, ucn_pkg::KIND_IPVFUTURE: begin
                return unres || sub || (b == ":");
            end
            ucn_pkg::KIND_HOST: begin
                return unres || sub;
            end
            ucn_pkg::KIND_QUERY, ucn_pkg::KIND_FRAGMENT: begin
                return pchar || (b == "/") || (b == "?");
            end
            default: begin
                return pchar || (b == "/");
            end
        endcase
    endfunction

    function automatic void clear_string_model();
        esc_model      = ESC_IDLE;
        hex_hi_model   = 8'h00;
        at_start_model = 1'b1;
        aborted_model  = 1'b0;
    endfunction

    // works out the words that one accepted byte causes and queues them
    function automatic void predict_words(input logic [7:0] b, input logic eos);
        t_norm_word words[$];
        bit         fail;
        int         hi;
        int         lo;
        logic [7:0] v;
        fail = 1'b0;
        if (eos) begin
            // terminator, flagged when the string was aborted, cut mid-escape or an empty scheme
            pending_words.push_back('{8'h00, 1'b1, 1'b1,
                aborted_model || (esc_model != ESC_IDLE) ||
                ((kind_model == ucn_pkg::KIND_SCHEME) && at_start_model)});
            clear_string_model();
            return;
        end
        if (aborted_model) return;

        if (kind_model == ucn_pkg::KIND_SCHEME) begin
            // no escapes in scheme mode, a pending one is simply forgotten
            esc_model = ESC_IDLE;
            if (char_ok(ucn_pkg::KIND_SCHEME, b) && (!at_start_model || is_letter(b)))
                words.push_back('{low_case(b), 1'b0, 1'b0, 1'b0});
            else
                fail = 1'b1;
            at_start_model = 1'b0;
        end else begin
            at_start_model = 1'b0;
            case (esc_model)
                ESC_IDLE: begin
                    if (b == ucn_pkg::CHAR_PERCENT) begin
                        esc_model = ESC_AFTER_PCT;
                        return;
                    end
                    if (char_ok(kind_model, b))
                        words.push_back('{b, 1'b0, 1'b0, 1'b0});
                    else
                        fail = 1'b1;
                end
                ESC_AFTER_PCT: begin
                    if (hex_digit(b) < 0) begin
                        fail = 1'b1;
                    end else begin
                        hex_hi_model = b;
                        esc_model    = ESC_AFTER_HI;
                        return;
                    end
                end
                default: begin
                    lo = hex_digit(b);
                    hi = hex_digit(hex_hi_model);
                    if ((lo < 0) || (hi < 0)) begin
                        fail = 1'b1;
                    end else begin
                        v = {hi[3:0], lo[3:0]};
                        esc_model = ESC_IDLE;
                        if (char_ok(kind_model, v)) begin
                            words.push_back('{v, 1'b0, 1'b0, 1'b0});
                        end else begin
                            // disallowed once decoded: re-escape with upper-case digits
                            words.push_back('{ucn_pkg::CHAR_PERCENT, 1'b0, 1'b0, 1'b0});
                            words.push_back('{up_case(hex_hi_model), 1'b0, 1'b0, 1'b0});
                            words.push_back('{up_case(b), 1'b0, 1'b0, 1'b0});
                        end
                    end
                end
            endcase
        end

        if (fail) begin
            aborted_model = 1'b1;
            esc_model     = ESC_IDLE;
            words         = {};
            words.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
        end
        if (words.size() > 0) begin
            words[words.size() - 1].run_last = 1'b1;
            foreach (words[i]) pending_words.push_back(words[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, every accepted word checked in order
    // ------------------------------------------------------------------
    initial begin
        t_norm_word want;
        word_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && word_ch.valid && word_ch.ready) begin
                if (pending_words.size() == 0) begin
                    $error("word with nothing expected: out_byte %0h", word_ch.out_byte);
                    mismatches++;
                end else begin
                    want = pending_words.pop_front();
                    if (word_ch.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, word_ch.out_byte);
                        mismatches++;
                    end
                    if (word_ch.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last, word_ch.run_last);
                        mismatches++;
                    end
                    if (word_ch.string_done !== want.string_done) begin
                        $error("string_done: expected %0b, got %0b",
                               want.string_done, word_ch.string_done);
                        mismatches++;
                    end
                    if (word_ch.error !== want.error) begin
                        $error("error: expected %0b, got %0b", want.error, word_ch.error);
                        mismatches++;
                    end
                end
            end
            word_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // byte side and register port
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic eos);
        // random gaps before the word, valid stays up across back-to-back words
        while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.in_byte       <= b;
        byte_ch.end_of_string <= eos;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        live_items++;
        predict_words(b, eos);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    // hold off input until every owed word is out and the pipe has emptied
    task automatic wait_quiet();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ucn_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [ucn_pkg::CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_KIND) kind_model = data[2:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return "0" + 8'(v);
        return (upper ? "A" : "a") + 8'(v - 4'd10);
    endfunction

    task automatic send_escape(input logic [7:0] v);
        send_word(ucn_pkg::CHAR_PERCENT, 1'b0);
        send_word(hex_char(v[7:4], 1'($urandom_range(0, 1))), 1'b0);
        send_word(hex_char(v[3:0], 1'($urandom_range(0, 1))), 1'b0);
    endtask

    function automatic logic [7:0] pick_allowed(input logic [2:0] kind);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 127)); while (!char_ok(kind, b));
        return b;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // kind is path out of reset: plain decode and a re-escape
    task automatic test_escape_decode();
        send_text("%41");
        send_text("%e9");
    endtask

    // extreme bytes: 0xff aborts, 0x00 is then dropped, the end word reports the abort
    task automatic test_abort();
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // unused kind code, then a switch to scheme with an escape half done
    task automatic test_midstring_kind();
        wait_quiet();
        write_reg(ADDR_KIND, ucn_pkg::CFG_DATA_W'(KIND_SPARE));
        send_text("%4");
        wait_quiet();
        // no such register, ignored
        write_reg(ADDR_SPARE, ucn_pkg::CFG_DATA_W'(ucn_pkg::KIND_HOST));
        write_reg(ADDR_KIND, ucn_pkg::CFG_DATA_W'(ucn_pkg::KIND_SCHEME));
        send_text("Z+");
        send_word(8'hA5, 1'b1);
    endtask

    // scheme: empty string and a digit in first place are both invalid
    task automatic test_scheme_start();
        send_word(8'h00, 1'b1);
        send_word("9", 1'b0);
        send_word(8'h5A, 1'b1);
    endtask

    // bad hex digit, and an escape cut short by the end word
    task automatic test_broken_escape();
        wait_quiet();
        write_reg(ADDR_KIND, ucn_pkg::CFG_DATA_W'(ucn_pkg::KIND_QUERY));
        send_text("?%z");
        send_word(8'h00, 1'b1);
        wait_quiet();
        write_reg(ADDR_KIND, ucn_pkg::CFG_DATA_W'(ucn_pkg::KIND_HOST));
        send_text("%4");
        send_word(8'h00, 1'b1);
        send_text("~");
        send_word(8'hFF, 1'b1);
    endtask

    // mostly well-formed strings with random content, some noise and broken escapes
    task automatic test_random_strings(input int target);
        int         len;
        int         pick;
        int         phase_start;
        int         phase_no;
        logic [2:0] next_kind;
        live_items  = 0;
        phase_start = 0;
        phase_no    = 0;
        steady      = 1'b1;
        while (live_items < target) begin
            if (live_items >= 80) steady = 1'b0;
            if ((phase_no == 0) || (live_items - phase_start >= 60)) begin
                // extremes first, then anything
                case (phase_no)
                    0:       next_kind = ucn_pkg::KIND_SCHEME;
                    1:       next_kind = ucn_pkg::KIND_IPVFUTURE;
                    2:       next_kind = KIND_SPARE;
                    default: next_kind = 3'($urandom_range(0, 7));
                endcase
                wait_quiet();
                write_reg(ADDR_KIND, ucn_pkg::CFG_DATA_W'(next_kind));
                phase_start = live_items;
                phase_no++;
            end
            len = $urandom_range(0, 10);
            for (int t = 0; t < len; t++) begin
                pick = $urandom_range(0, 99);
                if ((kind_model == ucn_pkg::KIND_SCHEME) && (t == 0) && (pick < 85)) begin
                    send_word(8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "a" : "A"),
                              1'b0);
                end else if (pick < 50) begin
                    send_word(pick_allowed(kind_model), 1'b0);
                end else if (pick < 80) begin
                    send_escape(8'($urandom_range(0, 255)));
                end else if (pick < 90) begin
                    send_word(8'($urandom_range(0, 255)), 1'b0);
                end else if (pick < 96) begin
                    send_word(ucn_pkg::CHAR_PERCENT, 1'b0);
                    send_word(8'($urandom_range(0, 255)), 1'b0);
                end else begin
                    // kind changed between two bytes of one string
                    wait_quiet();
                    write_reg(ADDR_KIND, ucn_pkg::CFG_DATA_W'($urandom_range(0, 7)));
                end
            end
            if ($urandom_range(0, 99) < 97) send_word(8'($urandom_range(0, 255)), 1'b1);
        end
        steady = 1'b0;
    endtask

    initial begin
        mismatches = 0;
        live_items = 0;
        steady     = 1'b0;
        kind_model = ucn_pkg::KIND_RESET;
        clear_string_model();

        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        byte_ch.valid         <= 1'b0;
        byte_ch.in_byte       <= 8'h00;
        byte_ch.end_of_string <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_escape_decode();
        test_abort();
        test_midstring_kind();
        test_scheme_start();
        test_broken_escape();
        test_random_strings(450);

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ucn_pkg.sv
design/ucn_stream_if.sv
design/ucn_front.sv
design/ucn_queue.sv
design/ucn_back.sv
design/uri_component_normalizer_core.sv
tb/uri_component_normalizer_core_tb.sv
